// ----- rtl/core/ois_pkg.sv -----
`default_nettype none

package ois_pkg;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_PRESENT   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    localparam int IN_BITS  = 40;
    localparam int OUT_BITS = 48;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RDIDX,
        S_RDWAIT,
        S_DONE
    } state_t;

    // input transaction, first field in the highest bits
    typedef struct packed {
        logic [3:0]         index;
        logic signed [31:0] value;
        logic [1:0]         command;
    } cmd_t;

    // result transaction, first field in the highest bits
    typedef struct packed {
        logic [4:0]         count;
        logic signed [31:0] read_value;
        logic               found;
        logic [2:0]         status;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/ordered_integer_set_store_core.sv -----
// Channel | Dir | Fields (low bit up)                                      | Handshake
// s_      | in  | command[1:0], value[33:2], index[37:34], pad to 40      | s_tvalid/s_tready
// m_      | out | status[2:0], found[3], read_value[35:4], count[40:36]   | m_tvalid/m_tready
//
// One command at a time. Every command first scans the stored entries through the
// single read port, one entry per cycle, stopping at the first match. A remove then
// compacts the tail, one entry per cycle (read at i+1, write at i); a read with an
// index in range then fetches that entry through the port (S_RDIDX, S_RDWAIT).
// Reset clears the state, the entry count and the pending and output-valid flags; the entry memory is not cleared.
// A finished result sits in the output register, so the next command is taken
// while m_tready is low; it waits in its last step only if the register is still full.
`default_nettype none

module ordered_integer_set_store_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // command[1:0], value[33:2], index[37:34]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // status[2:0], found[3], read_value[35:4], count[40:36]
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int XW = (CW > 4) ? CW : 4;
    localparam int OW = (CW > 5) ? CW : 5;

    ois_pkg::state_t state_reg, state_next;

    logic [1:0]         cmd_reg, cmd_next;
    logic signed [31:0] val_reg, val_next;
    logic [3:0]         idx_reg, idx_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic [CW-1:0]      paddr_reg, paddr_next;
    logic               found_reg, found_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [2:0]         status_reg, status_next;
    logic               out_vld_reg, out_vld_next;
    ois_pkg::result_t   out_reg, out_next;

    // entry memory, one read and one write port, registered read
    logic [31:0]   mem [CAPACITY];
    logic [31:0]   mem_q_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    ois_pkg::cmd_t in_cmd;
    logic          hit;
    logic          full;
    logic          idx_ok;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] cnt_x;
    logic [CW-1:0] paddr_m1;
    logic [OW-1:0] cnt_o;

    assign in_cmd   = ois_pkg::cmd_t'(s_tdata[37:0]);
    assign hit      = pend_reg && (mem_q_reg == val_reg);
    assign full     = (cnt_reg == CW'(CAPACITY));
    assign idx_x    = XW'(idx_reg);
    assign cnt_x    = XW'(cnt_reg);
    assign idx_ok   = (idx_x < cnt_x);
    assign paddr_m1 = paddr_reg - CW'(1);
    assign cnt_o    = OW'(cnt_reg);

    assign s_tready = (state_reg == ois_pkg::S_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(ois_pkg::OUT_BITS - $bits(ois_pkg::result_t)){1'b0}}, out_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ois_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            out_vld_reg <= out_vld_next;
        end
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        ptr_reg    <= ptr_next;
        paddr_reg  <= paddr_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        val_next     = val_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        ptr_next     = ptr_reg;
        pend_next    = pend_reg;
        paddr_next   = paddr_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        status_next  = status_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg;
        rd_en        = 1'b0;
        rd_addr      = ptr_reg[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = cnt_reg[AW-1:0];
        wr_data      = val_reg;

        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ois_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = in_cmd.command;
                    val_next   = in_cmd.value;
                    idx_next   = in_cmd.index;
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    state_next = ois_pkg::S_SCAN;
                end
            end
            ois_pkg::S_SCAN: begin
                if (hit || (!pend_reg && ptr_reg >= cnt_reg)) begin
                    // search finished; hit tells whether the value is held
                    pend_next   = 1'b0;
                    found_next  = hit;
                    pos_next    = paddr_reg[AW-1:0];
                    status_next = ois_pkg::ST_OK;
                    state_next  = ois_pkg::S_DONE;
                    case (cmd_reg)
                        ois_pkg::CMD_INSERT: begin
                            if (hit) begin
                                status_next = ois_pkg::ST_PRESENT;
                            end else if (full) begin
                                status_next = ois_pkg::ST_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        ois_pkg::CMD_REMOVE: begin
                            if (hit) begin
                                ptr_next   = paddr_reg + CW'(1);
                                state_next = ois_pkg::S_SHIFT;
                            end else begin
                                status_next = ois_pkg::ST_NOT_FOUND;
                            end
                        end
                        ois_pkg::CMD_LOOKUP: begin
                            if (!hit) begin
                                status_next = ois_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (idx_ok) begin
                                state_next = ois_pkg::S_RDIDX;
                            end else begin
                                status_next = ois_pkg::ST_RANGE;
                            end
                        end
                    endcase
                end else if (ptr_reg < cnt_reg) begin
                    rd_en      = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg;
                    ptr_next   = ptr_reg + CW'(1);
                end else begin
                    pend_next = 1'b0;
                end
            end
            ois_pkg::S_SHIFT: begin
                // read entry i+1, then write it to i in the following cycle
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = paddr_m1[AW-1:0];
                    wr_data = mem_q_reg;
                end
                if (ptr_reg < cnt_reg) begin
                    rd_en      = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg;
                    ptr_next   = ptr_reg + CW'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        cnt_next   = cnt_reg - CW'(1);
                        state_next = ois_pkg::S_DONE;
                    end
                end
            end
            ois_pkg::S_RDIDX: begin
                rd_en      = 1'b1;
                rd_addr    = idx_x[AW-1:0];
                state_next = ois_pkg::S_RDWAIT;
            end
            ois_pkg::S_RDWAIT: begin
                state_next = ois_pkg::S_DONE;
            end
            ois_pkg::S_DONE: begin
                if (!out_vld_reg || m_tready) begin
                    out_next.status     = status_reg;
                    out_next.found      = found_reg;
                    out_next.read_value = '0;
                    if (cmd_reg == ois_pkg::CMD_READ && status_reg == ois_pkg::ST_OK) begin
                        out_next.read_value = mem_q_reg;
                    end
                    out_next.count = cnt_o[4:0];
                    out_vld_next   = 1'b1;
                    state_next     = ois_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ois_pkg::S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_dup_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.status == ois_pkg::ST_PRESENT) |-> out_reg.found)
        else $error("duplicate status without found flag");

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.status == ois_pkg::ST_RANGE) |-> (out_reg.read_value == '0))
        else $error("out of range read returned data");

    a_scan_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ois_pkg::S_SCAN && pend_reg) |-> (paddr_reg < cnt_reg))
        else $error("scan compared an entry beyond the count");
`endif

endmodule

`default_nettype wire

// ----- test/set_store_checker.sv -----
`default_nettype none

module set_store_checker #(
    parameter int CAPACITY = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,   // command[1:0], value[33:2], index[37:34]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,   // status[2:0], found[3], read_value[35:4], count[40:36]
    output int               fail_count,
    output int               results_due
);

    logic signed [31:0] set_words [CAPACITY];
    int                 held = 0;
    ois_pkg::result_t   expected_q[$];
    int                 mismatch_total = 0;
    int                 due_count = 0;

    assign fail_count  = mismatch_total;
    assign results_due = due_count;

    // Apply one command to the local copy of the set and return its result.
    function automatic ois_pkg::result_t apply_set_command(input ois_pkg::cmd_t c);
        ois_pkg::result_t r;
        int      pos;
        int      i;
        logic    hit;
        pos = held;
        for (i = held - 1; i >= 0; i--) begin
            if (set_words[i] == c.value) pos = i;
        end
        hit          = (pos < held);
        r.status     = ois_pkg::ST_OK;
        r.found      = hit;
        r.read_value = '0;
        case (c.command)
            ois_pkg::CMD_INSERT: begin
                if (hit) begin
                    r.status = ois_pkg::ST_PRESENT;
                end else if (held >= CAPACITY) begin
                    r.status = ois_pkg::ST_FULL;
                end else begin
                    set_words[held] = c.value;
                    held++;
                end
            end
            ois_pkg::CMD_REMOVE: begin
                if (hit) begin
                    // close the gap, order of the rest kept
                    for (i = pos; i < held - 1; i++) set_words[i] = set_words[i + 1];
                    held--;
                end else begin
                    r.status = ois_pkg::ST_NOT_FOUND;
                end
            end
            ois_pkg::CMD_LOOKUP: begin
                if (!hit) r.status = ois_pkg::ST_NOT_FOUND;
            end
            default: begin
                if (int'(c.index) < held) r.read_value = set_words[c.index];
                else r.status = ois_pkg::ST_RANGE;
            end
        endcase
        r.count = 5'(held);
        return r;
    endfunction

    always @(posedge aclk) begin
        ois_pkg::result_t want;
        ois_pkg::result_t got;
        if (!aresetn) begin
            held = 0;
            expected_q.delete();
        end else begin
            // output side first: a result never belongs to the command taken at the same edge
            if (m_tvalid && m_tready) begin
                got = ois_pkg::result_t'(m_tdata[40:0]);
                if (expected_q.size() == 0) begin
                    if (mismatch_total < 10)
                        $display("unexpected result transaction %h", m_tdata);
                    mismatch_total++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status || got.found !== want.found ||
                        got.read_value !== want.read_value || got.count !== want.count ||
                        m_tdata[47:41] !== 7'd0) begin
                        if (mismatch_total < 10)
                            $display({"mismatch: want st %0d fnd %0b val %h cnt %0d, ",
                                      "got st %0d fnd %0b val %h cnt %0d pad %h"},
                                     want.status, want.found, want.read_value, want.count,
                                     got.status, got.found, got.read_value, got.count,
                                     m_tdata[47:41]);
                        mismatch_total++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_q.insert(expected_q.size(),
                                  apply_set_command(ois_pkg::cmd_t'(s_tdata[37:0])));
        end
        due_count <= expected_q.size();
    end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`default_nettype none

module tb_top;

    localparam int CAPACITY    = 16;
    localparam int ITEMS       = 1400;
    localparam int QUIET_ITEMS = 200;
    localparam int HOLD_AT     = 600;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 2 * CAPACITY + 10;
    localparam int LIMIT       = 400000;
    localparam int SEGMENT     = 64;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    int          fail_count;
    int          results_due;

    int                 sent_count = 0;
    logic               quiet = 1'b0;
    logic               hold_done = 1'b0;
    int                 cycle_count = 0;
    logic signed [31:0] pool [24];

    ordered_integer_set_store_core #(.CAPACITY(CAPACITY)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    set_store_checker #(.CAPACITY(CAPACITY)) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Called right after a rising edge; returns at the edge that takes the transaction.
    task automatic send_command(input logic [1:0] op, input logic signed [31:0] val,
                                input logic [3:0] idx);
        ois_pkg::cmd_t c;
        c.command = op;
        c.value   = val;
        c.index   = idx;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, c};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
        if (sent_count >= ITEMS - QUIET_ITEMS) quiet = 1'b1;
    endtask

    // mode 0 grows the set, 1 drains it, 2 is mixed
    function automatic logic [1:0] pick_command(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0:       return (r < 55) ? ois_pkg::CMD_INSERT : (r < 65) ? ois_pkg::CMD_REMOVE :
                            (r < 80) ? ois_pkg::CMD_LOOKUP : ois_pkg::CMD_READ;
            1:       return (r < 15) ? ois_pkg::CMD_INSERT : (r < 65) ? ois_pkg::CMD_REMOVE :
                            (r < 80) ? ois_pkg::CMD_LOOKUP : ois_pkg::CMD_READ;
            default: return (r < 30) ? ois_pkg::CMD_INSERT : (r < 55) ? ois_pkg::CMD_REMOVE :
                            (r < 75) ? ois_pkg::CMD_LOOKUP : ois_pkg::CMD_READ;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value();
        // mostly pool values so hits and a full store happen; some raw noise
        if ($urandom_range(0, 9) == 0) return $urandom;
        return pool[$urandom_range(0, 23)];
    endfunction

    initial begin
        int mode;
        int k;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        pool[0] = 32'sh8000_0000;
        pool[1] = 32'sh7FFF_FFFF;
        pool[2] = 32'sh0000_0000;
        pool[3] = -32'sd1;
        for (k = 4; k < 24; k++) pool[k] = $urandom;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty store, extremes, duplicates, removal at each end and the middle
        send_command(ois_pkg::CMD_READ,   32'sh0000_0000, 4'd0);
        send_command(ois_pkg::CMD_LOOKUP, 32'sh0000_0000, 4'd0);
        send_command(ois_pkg::CMD_REMOVE, 32'sh0000_0000, 4'd0);
        send_command(ois_pkg::CMD_INSERT, 32'sh8000_0000, 4'd0);
        send_command(ois_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 4'd15);
        send_command(ois_pkg::CMD_INSERT, 32'sh0000_0000, 4'd0);
        send_command(ois_pkg::CMD_INSERT, -32'sd1,        4'd0);
        send_command(ois_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 4'd0);
        send_command(ois_pkg::CMD_LOOKUP, 32'sh8000_0000, 4'd0);
        send_command(ois_pkg::CMD_READ,   32'sh0000_0000, 4'd3);
        send_command(ois_pkg::CMD_READ,   32'sh0000_0000, 4'd4);
        send_command(ois_pkg::CMD_READ,   -32'sd1,        4'd15);
        send_command(ois_pkg::CMD_REMOVE, 32'sh8000_0000, 4'd0);
        send_command(ois_pkg::CMD_REMOVE, 32'sh0000_0000, 4'd0);
        send_command(ois_pkg::CMD_REMOVE, -32'sd1,        4'd0);
        send_command(ois_pkg::CMD_READ,   32'sh0000_0000, 4'd0);
        send_command(ois_pkg::CMD_REMOVE, 32'sh7FFF_FFFF, 4'd0);
        send_command(ois_pkg::CMD_LOOKUP, 32'sh7FFF_FFFF, 4'd15);
        send_command(ois_pkg::CMD_READ,   32'sh0000_0000, 4'd15);

        // fill to capacity, overflow, read the last slot, then free one slot
        for (k = 0; k < 17; k++) send_command(ois_pkg::CMD_INSERT, pool[k], 4'($urandom));
        send_command(ois_pkg::CMD_READ,   pick_value(), 4'd15);
        send_command(ois_pkg::CMD_READ,   pick_value(), 4'd0);
        send_command(ois_pkg::CMD_REMOVE, pool[8],      4'($urandom));
        send_command(ois_pkg::CMD_INSERT, pool[20],     4'($urandom));
        send_command(ois_pkg::CMD_LOOKUP, pool[20],     4'($urandom));

        mode = 0;
        while (sent_count < ITEMS) begin
            if (sent_count % SEGMENT == 0) mode = $urandom_range(0, 2);
            send_command(pick_command(mode), pick_value(), 4'($urandom_range(0, 15)));
        end
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (results_due != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // result side: short random stalls, one long hold-off so the input backs up
    initial begin
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!hold_done && sent_count >= HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

endmodule

`default_nettype wire
